// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

// ===== hdl/pidv_pkg.sv =====
// Types and constants of the velocity PID core.
package pidv_pkg;

    localparam int VEL_W      = 16;
    localparam int GAIN_W     = 15;
    localparam int PROD_W     = 31;
    localparam int MAG_W      = 30;
    localparam int RECIP_W    = 31;
    localparam int CFG_ADDR_W = 2;

    // ceil(2^37 / 100); exact floor(m / 100) for every m below 2^30
    localparam logic [RECIP_W-1:0] RECIP_100   = 31'd1374389535;
    localparam int                 RECIP_SHIFT = 37;

    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STALL_LIMIT   = 2'd3;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 15'd130;
    localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST = 15'd0;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST    = 15'd0;
    localparam logic [GAIN_W-1:0] STALL_LIMIT_RST   = 15'd1024;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_SET  = 1'b1
    } func_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integral_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] stall_limit;
    } cfg_t;

    typedef struct packed {
        func_t                    func;
        logic signed [PROD_W-1:0] prod_p;
        logic signed [PROD_W-1:0] prod_i;
        logic signed [PROD_W-1:0] prod_d;
    } prod_t;

    typedef struct packed {
        func_t            func;
        logic [VEL_W-1:0] quot_p;
        logic [VEL_W-1:0] quot_i;
        logic [VEL_W-1:0] quot_d;
    } quot_t;

endpackage

// ===== hdl/pidv_cfg_regs.sv =====
// Gain and stall limit registers behind the write port.
module pidv_cfg_regs import pidv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PROP_GAIN:     cfg_next.prop_gain     = cfg_wdata;
                REG_INTEGRAL_GAIN: cfg_next.integral_gain = cfg_wdata;
                REG_DERIV_GAIN:    cfg_next.deriv_gain    = cfg_wdata;
                REG_STALL_LIMIT:   cfg_next.stall_limit   = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain     <= PROP_GAIN_RST;
            cfg_reg.integral_gain <= INTEGRAL_GAIN_RST;
            cfg_reg.deriv_gain    <= DERIV_GAIN_RST;
            cfg_reg.stall_limit   <= STALL_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/pidv_front.sv =====
// Input register, error and difference, and the three gain products.
module pidv_front import pidv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  func_t            in_func,
    input  logic [VEL_W-1:0] in_vel,
    output logic             out_valid,
    input  logic             out_ready,
    output prod_t            out_prod
);

    logic             in_valid_reg, in_valid_next;
    func_t            in_func_reg;
    logic [VEL_W-1:0] in_vel_reg;
    logic             prod_valid_reg, prod_valid_next;
    prod_t            prod_reg, prod_next;
    logic [VEL_W-1:0] target_reg, target_next;
    logic [VEL_W-1:0] last_err_reg, last_err_next;

    logic               in_load;
    logic               prod_load;
    logic [VEL_W-1:0]   err;
    logic [VEL_W-1:0]   diff;
    logic signed [31:0] mul_p, mul_i, mul_d;

    assign prod_load = in_valid_reg && (!prod_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || prod_load;
    assign in_load   = in_valid && in_ready;

    assign err  = target_reg - in_vel_reg;
    assign diff = err - last_err_reg;

    assign mul_p = $signed({1'b0, cfg.prop_gain})     * $signed(err);
    assign mul_i = $signed({1'b0, cfg.integral_gain}) * $signed(err);
    assign mul_d = $signed({1'b0, cfg.deriv_gain})    * $signed(diff);

    always_comb begin
        in_valid_next   = in_load ? 1'b1 : (prod_load ? 1'b0 : in_valid_reg);
        prod_valid_next = prod_load ? 1'b1 : (out_ready ? 1'b0 : prod_valid_reg);
        prod_next       = prod_reg;
        target_next     = target_reg;
        last_err_next   = last_err_reg;
        if (prod_load) begin
            prod_next.func   = in_func_reg;
            prod_next.prod_p = mul_p[PROD_W-1:0];
            prod_next.prod_i = mul_i[PROD_W-1:0];
            prod_next.prod_d = mul_d[PROD_W-1:0];
            unique case (in_func_reg)
                FUNC_SET:  target_next   = in_vel_reg;
                FUNC_TICK: last_err_next = err;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            target_reg     <= '0;
            last_err_reg   <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
            target_reg     <= target_next;
            last_err_reg   <= last_err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_func_reg <= in_func;
            in_vel_reg  <= in_vel;
        end
        prod_reg <= prod_next;
    end

    assign out_valid = prod_valid_reg;
    assign out_prod  = prod_reg;

endmodule

// ===== hdl/pidv_scale.sv =====
// Divide-by-100 stage: reciprocal multiply on the magnitude, truncating toward zero.
module pidv_scale import pidv_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  prod_t in_prod,
    output logic  out_valid,
    input  logic  out_ready,
    output quot_t out_quot
);

    function automatic logic [VEL_W-1:0] div100_trunc(input logic signed [PROD_W-1:0] prod);
        logic                       neg;
        logic [PROD_W-1:0]          neg_prod;
        logic [MAG_W-1:0]           mag;
        logic [MAG_W+RECIP_W-1:0]   scaled;
        logic [VEL_W-1:0]           q;
        neg      = prod[PROD_W-1];
        neg_prod = -prod;
        mag      = neg ? neg_prod[MAG_W-1:0] : prod[MAG_W-1:0];
        scaled   = {{RECIP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP_100};
        q        = scaled[RECIP_SHIFT +: VEL_W];
        return neg ? VEL_W'(~q + 1'b1) : q;
    endfunction

    logic  quot_valid_reg, quot_valid_next;
    quot_t quot_reg, quot_next;
    logic  load;

    assign in_ready = !quot_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        quot_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : quot_valid_reg);
        quot_next       = quot_reg;
        if (load) begin
            quot_next.func   = in_prod.func;
            quot_next.quot_p = div100_trunc(in_prod.prod_p);
            quot_next.quot_i = div100_trunc(in_prod.prod_i);
            quot_next.quot_d = div100_trunc(in_prod.prod_d);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quot_valid_reg <= 1'b0;
        end else begin
            quot_valid_reg <= quot_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
    end

    assign out_valid = quot_valid_reg;
    assign out_quot  = quot_reg;

endmodule

// ===== hdl/pidv_accum.sv =====
// Integral and power accumulation, stall cut-off and the result register.
module pidv_accum import pidv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [GAIN_W-1:0] stall_limit,
    input  logic              in_valid,
    output logic              in_ready,
    input  quot_t             in_quot,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [VEL_W-1:0]  out_power,
    output logic              out_stall
);

    logic [VEL_W-1:0] integ_acc_reg, integ_acc_next;
    logic [VEL_W-1:0] power_reg, power_next;
    logic             stall_reg, stall_next;
    logic             out_valid_reg, out_valid_next;
    logic [VEL_W-1:0] out_power_reg, out_power_next;
    logic             out_stall_reg, out_stall_next;

    logic                   consume;
    logic [VEL_W-1:0]       integ_sum;
    logic [VEL_W-1:0]       pid_sum;
    logic [VEL_W-1:0]       power_sum;
    logic signed [VEL_W:0]  pw_ext;
    logic signed [VEL_W:0]  lim_ext;
    logic                   trip;

    assign in_ready = (in_quot.func == FUNC_SET) || !out_valid_reg || out_ready;
    assign consume  = in_valid && in_ready;

    assign integ_sum = integ_acc_reg + in_quot.quot_i;
    assign pid_sum   = in_quot.quot_p + integ_sum + in_quot.quot_d;
    assign power_sum = power_reg + pid_sum;
    assign pw_ext    = $signed({power_sum[VEL_W-1], power_sum});
    assign lim_ext   = $signed({2'b00, stall_limit});
    assign trip      = (pw_ext > lim_ext) || (pw_ext < -lim_ext);

    always_comb begin
        integ_acc_next = integ_acc_reg;
        power_next     = power_reg;
        stall_next     = stall_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_power_next = out_power_reg;
        out_stall_next = out_stall_reg;
        if (consume) begin
            unique case (in_quot.func)
                FUNC_SET: begin
                    stall_next = 1'b0;
                end
                FUNC_TICK: begin
                    out_valid_next = 1'b1;
                    if (trip) begin
                        integ_acc_next = '0;
                        power_next     = '0;
                        stall_next     = 1'b1;
                        out_power_next = '0;
                        out_stall_next = 1'b1;
                    end else begin
                        integ_acc_next = integ_sum;
                        power_next     = power_sum;
                        out_power_next = power_sum;
                        out_stall_next = stall_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_acc_reg <= '0;
            power_reg     <= '0;
            stall_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            integ_acc_reg <= integ_acc_next;
            power_reg     <= power_next;
            stall_reg     <= stall_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_power_reg <= out_power_next;
        out_stall_reg <= out_stall_next;
    end

    assign out_valid = out_valid_reg;
    assign out_power = out_power_reg;
    assign out_stall = out_stall_reg;

endmodule

// ===== hdl/pid_velocity_loop_with_stall_core.sv =====
// Velocity PID core with stall cut-off: top level.
//
// Takes one beat per clock while the result side does not stall it. A tick beat (tuser 0)
// carries the measured velocity and gives one result beat after these registered steps: input
// register, error and gain products, divide-by-100 through a reciprocal multiply, then
// integral/power accumulation with the stall check into the result register. A set-target
// beat (tuser 1) stores the target and clears the stall flag and gives no result. Target and
// last error live in the product stage and the integral, power and stall flag in the last
// stage, each updated in beat order, so back-to-back beats stream at one per cycle; m_tready
// low backs the stages up one at a time before s_tready drops. The user must write gains
// and the stall limit through the cfg port while the core is idle; the core does not enforce it.
`include "assert_macros.svh"

module pid_velocity_loop_with_stall_core import pidv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] velocity_value
    input  logic                  s_tuser,   // [0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] motor_power
    output logic                  m_tuser    // [0] stall_res
);

    cfg_t  cfg;
    logic  prod_valid, prod_ready;
    prod_t prod;
    logic  quot_valid, quot_ready;
    quot_t quot;

    pidv_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (func_t'(s_tuser)),
        .in_vel    (s_tdata),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_prod  (prod)
    );

    pidv_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_prod   (prod),
        .out_valid (quot_valid),
        .out_ready (quot_ready),
        .out_quot  (quot)
    );

    pidv_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stall_limit (cfg.stall_limit),
        .in_valid    (quot_valid),
        .in_ready    (quot_ready),
        .in_quot     (quot),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_power   (m_tdata),
        .out_stall   (m_tuser)
    );

    logic signed [16:0] chk_power;
    logic signed [16:0] chk_limit;

    assign chk_power = $signed({m_tdata[15], m_tdata});
    assign chk_limit = $signed({2'b00, cfg.stall_limit});

    // input backs up only behind a result that is waiting
    `ASSERT_PROP(a_stall_needs_held_result, aclk, aresetn,
                 !s_tready |-> (m_tvalid && !m_tready), "input stalled with no held result")
    // a result without the stall flag never exceeds the limit
    `ASSERT_NEVER(a_power_within_limit, aclk, aresetn,
                  m_tvalid && !m_tuser && ((chk_power > chk_limit) || (chk_power < -chk_limit)),
                  "power beyond stall limit without stall")
    // a taken result is not shown again unless a new item reaches the last stage
    `ASSERT_PROP(a_pipe_drains, aclk, aresetn,
                 (m_tvalid && m_tready && !quot_valid) |=> !m_tvalid,
                 "result repeated without new item")

endmodule

// ===== sim/pid_velocity_loop_with_stall_core_tb.sv =====
// Self-checking stream testbench for the velocity PID core with stall cut-off.
`timescale 1ns / 100ps

module pid_velocity_loop_with_stall_core_tb;
    import pidv_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PIPE_SETTLE    = 12;
    localparam int MAX_REPORTS    = 10;

    localparam int TX_STREAM = 0;
    localparam int TX_BURSTY = 1;
    localparam int TX_SPARSE = 2;

    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_LONG     = 3;

    typedef struct packed {
        func_t       func;
        logic [15:0] vel;
    } vel_item_t;

    typedef struct packed {
        logic [15:0] power;
        logic        stall;
    } drive_beat_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [GAIN_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tuser;

    pid_velocity_loop_with_stall_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // predictor state and register copy
    cfg_t        gains_model;
    logic [15:0] tgt_model;
    logic [15:0] last_err_model;
    logic [15:0] integ_model;
    logic [15:0] power_model;
    logic        stall_model;

    vel_item_t   item_q[$];
    drive_beat_t drive_expect_q[$];

    int items_queued   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int tick_count     = 0;
    int set_count      = 0;
    int trip_count     = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;
    int phase_count    = 0;

    int tx_mode = TX_STREAM;
    int rx_mode = RX_ALWAYS;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [15:0] scale_by_gain(logic [GAIN_W-1:0] gain, logic [15:0] x);
        int prod;
        int q;
        prod = int'({17'd0, gain}) * int'($signed(x));
        q = prod / 100;
        return q[15:0];
    endfunction

    task automatic predict_drive(input func_t f, input logic [15:0] vel);
        logic [15:0] err;
        logic [15:0] diff;
        logic [15:0] p;
        logic [15:0] d;
        int          pw;
        int          lim;
        drive_beat_t beat;
        if (f == FUNC_SET) begin
            tgt_model   = vel;
            stall_model = 1'b0;
            set_count++;
        end else begin
            err            = tgt_model - vel;
            diff           = err - last_err_model;
            last_err_model = err;
            p              = scale_by_gain(gains_model.prop_gain, err);
            integ_model    = integ_model + scale_by_gain(gains_model.integral_gain, err);
            d              = scale_by_gain(gains_model.deriv_gain, diff);
            power_model    = power_model + 16'(p + integ_model + d);
            pw  = int'($signed(power_model));
            lim = int'({17'd0, gains_model.stall_limit});
            if (pw > lim || pw < -lim) begin
                stall_model = 1'b1;
                integ_model = '0;
                power_model = '0;
                beat.power  = '0;
                trip_count++;
            end else begin
                beat.power = power_model;
            end
            beat.stall = stall_model;
            drive_expect_q.push_back(beat);
            tick_count++;
        end
    endtask

    task automatic note_mismatch(input string what, input drive_beat_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s): expected power %0d stall %0b, got power %0d stall %0b",
                     what, $signed(want.power), want.stall, $signed(m_tdata), m_tuser);
    endtask

    // acceptance, prediction, checking and watchdog
    logic        in_beat_taken = 1'b0;
    drive_beat_t want_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_beat_taken <= 1'b0;
            idle_cycles = 0;
        end else begin
            in_beat_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                predict_drive(func_t'(s_tuser), s_tdata);
                items_accepted++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (drive_expect_q.size() == 0) begin
                    note_mismatch("no beat expected", '0);
                end else begin
                    want_beat = drive_expect_q.pop_front();
                    if (m_tdata !== want_beat.power || m_tuser !== want_beat.stall)
                        note_mismatch("field", want_beat);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // input driver: bursts with gaps, occasional hold until all results are back
    vel_item_t next_item;
    int        burst_left = 0;
    int        gap_left   = 0;
    bit        drain_hold = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_beat_taken) begin
            if (drain_hold && drive_expect_q.size() == 0)
                drain_hold = 1'b0;
            if (drain_hold) begin
                s_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (item_q.size() != 0) begin
                next_item = item_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.vel;
                s_tuser  <= next_item.func;
                if (burst_left <= 1) begin
                    case (tx_mode)
                        TX_STREAM: begin
                            burst_left = 1000;
                            gap_left   = 0;
                        end
                        TX_BURSTY: begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(0, 6);
                        end
                        default: begin
                            burst_left = $urandom_range(1, 4);
                            gap_left   = $urandom_range(0, 20);
                        end
                    endcase
                    if ($urandom_range(0, 24) == 0)
                        drain_hold = 1'b1;
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver stall patterns
    int rx_tick       = 0;
    int rx_stall_left = 0;

    always @(negedge aclk) begin
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= ((rx_tick % 7) < 4);
            default: begin
                if (rx_stall_left > 0) begin
                    m_tready <= 1'b0;
                    rx_stall_left--;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        rx_stall_left = $urandom_range(5, 30);
                end
            end
        endcase
    end

    task automatic push_item(input func_t f, input logic [15:0] vel);
        vel_item_t it;
        it.func = f;
        it.vel  = vel;
        item_q.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [GAIN_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        case (addr)
            REG_PROP_GAIN:     gains_model.prop_gain     = val;
            REG_INTEGRAL_GAIN: gains_model.integral_gain = val;
            REG_DERIV_GAIN:    gains_model.deriv_gain    = val;
            default:           gains_model.stall_limit   = val;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all_regs(input int kp, input int ki, input int kd, input int lim);
        write_reg(REG_PROP_GAIN, GAIN_W'(kp));
        write_reg(REG_INTEGRAL_GAIN, GAIN_W'(ki));
        write_reg(REG_DERIV_GAIN, GAIN_W'(kd));
        write_reg(REG_STALL_LIMIT, GAIN_W'(lim));
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || drive_expect_q.size() != 0)
            @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    // mostly ticks near the current target so the loop settles; some wild ticks and sets
    logic [15:0] gen_target = '0;

    task automatic gen_items(input int n);
        int          r;
        logic [15:0] v;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
                if ($urandom_range(0, 1) != 0)
                    v = 16'($urandom_range(0, 65535));
                else
                    v = 16'($urandom_range(0, 4000)) - 16'd2000;
                gen_target = v;
                push_item(FUNC_SET, v);
            end else if (r < 20) begin
                push_item(FUNC_TICK, 16'($urandom_range(0, 65535)));
            end else begin
                v = gen_target + 16'($urandom_range(0, 400)) - 16'd200;
                push_item(FUNC_TICK, v);
            end
        end
    endtask

    initial begin
        gains_model.prop_gain     = PROP_GAIN_RST;
        gains_model.integral_gain = INTEGRAL_GAIN_RST;
        gains_model.deriv_gain    = DERIV_GAIN_RST;
        gains_model.stall_limit   = STALL_LIMIT_RST;
        tgt_model      = '0;
        last_err_model = '0;
        integ_model    = '0;
        power_model    = '0;
        stall_model    = 1'b0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset gains: truncation, trip, stalled ticks, wrap of the error
        phase_count++;
        push_item(FUNC_SET, 16'd0);
        push_item(FUNC_TICK, 16'd0);
        push_item(FUNC_TICK, 16'd5);
        push_item(FUNC_TICK, 16'hFFF9);
        push_item(FUNC_TICK, 16'd787);
        push_item(FUNC_TICK, 16'd0);
        push_item(FUNC_TICK, 16'd1);
        push_item(FUNC_SET, 16'h7FFF);
        push_item(FUNC_TICK, 16'h8000);
        push_item(FUNC_TICK, 16'h7FFF);
        push_item(FUNC_SET, 16'h8000);
        push_item(FUNC_TICK, 16'h7FFF);
        push_item(FUNC_SET, 16'hFFFF);
        push_item(FUNC_TICK, 16'd0);
        push_item(FUNC_TICK, 16'h8000);
        wait_idle();

        // largest gains and limit: quotient overflow
        phase_count++;
        tx_mode = TX_BURSTY;
        rx_mode = RX_RANDOM;
        write_all_regs(32767, 32767, 32767, 32767);
        push_item(FUNC_SET, 16'd0);
        push_item(FUNC_TICK, 16'h8000);
        push_item(FUNC_TICK, 16'h7FFF);
        push_item(FUNC_TICK, 16'd1);
        push_item(FUNC_TICK, 16'hFFFF);
        push_item(FUNC_SET, 16'd100);
        push_item(FUNC_TICK, 16'd100);
        push_item(FUNC_TICK, 16'd0);
        gen_items(60);
        wait_idle();

        for (int p = 2; p <= 9; p++) begin
            phase_count++;
            tx_mode = p % 3;
            rx_mode = p % 4;
            case (p)
                2: write_all_regs(0, 0, 0, 0);
                3: write_all_regs($urandom_range(1, 300), $urandom_range(0, 50),
                                  $urandom_range(0, 100), 0);
                4: write_all_regs($urandom_range(0, 400), $urandom_range(0, 100),
                                  $urandom_range(0, 400), 32767);
                5: write_all_regs($urandom_range(0, 32767), $urandom_range(0, 32767),
                                  $urandom_range(0, 32767), $urandom_range(0, 32767));
                default: write_all_regs($urandom_range(50, 300), $urandom_range(0, 40),
                                        $urandom_range(0, 200), $urandom_range(200, 4000));
            endcase
            gen_items(72);
            wait_idle();
        end

        while (drive_expect_q.size() != 0) begin
            note_mismatch("beat never arrived", drive_expect_q.pop_front());
        end

        $display("ran %0d phases: %0d ticks and %0d target sets accepted, %0d results checked",
                 phase_count, tick_count, set_count, results_seen);
        $display("stall cut-offs predicted: %0d, mismatches: %0d", trip_count, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pidv_pkg.sv
hdl/pidv_cfg_regs.sv
hdl/pidv_front.sv
hdl/pidv_scale.sv
hdl/pidv_accum.sv
hdl/pid_velocity_loop_with_stall_core.sv
sim/pid_velocity_loop_with_stall_core_tb.sv
